>>> src/sbpp_pkg.sv
// Package for the sub-byte pixel packer: types, register indexes and depth codes.
// No dependencies; every other file of the block refers to it by scoped names.
package sbpp_pkg;

    localparam int PixelW = 8;
    localparam int CfgW   = 13;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    typedef enum logic [1:0] {
        DEPTH_1 = 2'd0,
        DEPTH_2 = 2'd1,
        DEPTH_4 = 2'd2,
        DEPTH_8 = 2'd3
    } depth_code_t;

    typedef enum logic [1:0] {
        REG_DEPTH = 2'd0,
        REG_WIDTH = 2'd1,
        REG_ROWS  = 2'd2
    } reg_index_t;

    // Configuration seen by the packing core
    typedef struct packed {
        depth_code_t       depth_code;
        logic [CfgW-1:0]   row_width;
        logic [CfgW-1:0]   row_count;
        logic              clear;
    } cfg_t;

    typedef struct packed {
        logic [PixelW-1:0] packed_byte;
        logic              end_of_row;
        logic              end_of_image;
    } result_t;

    // Bits per pixel for a depth code
    function automatic logic [3:0] depth_bits(depth_code_t code);
        logic [3:0] bits;
        begin
            case (code)
                DEPTH_1: bits = 4'd1;
                DEPTH_2: bits = 4'd2;
                DEPTH_4: bits = 4'd4;
                DEPTH_8: bits = 4'd8;
                default: bits = 4'd8;
            endcase
            return bits;
        end
    endfunction

endpackage

>>> src/sub_byte_pixel_packer.sv
// Sub-byte pixel packer: packs 1, 2 or 4 bit pixels MSB first into bytes, 8 bit passes.
// Pixels are registered at the input; packed bytes are registered at the output.
// Throughput: one pixel per cycle, set by the single-pass shift/OR between the input
// register and the result register; the result stage holds two items before stalling.
// Reset (rst_n, asynchronous): depth 8 bits, one pixel per row, one row; packing empty.
// Depends on sbpp_pkg, sbpp_cfg_regs, sbpp_pack_core and sbpp_out_skid.
module sub_byte_pixel_packer
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbpp_pkg::AddrW-1:0]    paddr,
    input  logic [sbpp_pkg::DataW-1:0]    pwdata,
    output logic [sbpp_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    // Pixel input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel_value
    // Packed byte output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] packed_byte
    output logic                          m_axis_tlast,   // end_of_row
    output logic                          m_axis_tuser    // [0] end_of_image
);

    sbpp_pkg::cfg_t     cfg;
    sbpp_pkg::result_t  res;
    sbpp_pkg::result_t  out_res;
    logic               res_valid;
    logic               out_room;

    // Registers; any write to a known register restarts the image
    sbpp_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Hold each item in the input register, then shift it into the partial byte
    // and advance the column and row counters in one pass
    sbpp_pack_core
    #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pixel  (s_axis_tdata),
        .out_room  (out_room),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register plus skid entry: a waiting byte does not stop the input
    sbpp_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (out_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = out_res.packed_byte;
    assign m_axis_tlast = out_res.end_of_row;
    assign m_axis_tuser = out_res.end_of_image;

endmodule

>>> src/sbpp_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on sbpp_pkg for the register indexes and the cfg_t struct.
module sbpp_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbpp_pkg::AddrW-1:0]  paddr,
    input  logic [sbpp_pkg::DataW-1:0]  pwdata,
    output logic [sbpp_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output sbpp_pkg::cfg_t              cfg
);

    sbpp_pkg::depth_code_t          depth_reg, depth_next;
    logic [sbpp_pkg::CfgW-1:0]      width_reg, width_next;
    logic [sbpp_pkg::CfgW-1:0]      rows_reg, rows_next;
    logic                           wr_en;
    logic                           hit;
    logic [1:0]                     index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[sbpp_pkg::AddrW-1:2];

    always_comb
    begin
        depth_next = depth_reg;
        width_next = width_reg;
        rows_next  = rows_reg;
        hit        = 1'b0;
        case (index)
            sbpp_pkg::REG_DEPTH:
            begin
                hit        = wr_en;
                depth_next = sbpp_pkg::depth_code_t'(pwdata[1:0]);
            end
            sbpp_pkg::REG_WIDTH:
            begin
                hit        = wr_en;
                width_next = pwdata[sbpp_pkg::CfgW-1:0];
            end
            sbpp_pkg::REG_ROWS:
            begin
                hit       = wr_en;
                rows_next = pwdata[sbpp_pkg::CfgW-1:0];
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= sbpp_pkg::DEPTH_8;
            width_reg <= sbpp_pkg::CfgW'(1);
            rows_reg  <= sbpp_pkg::CfgW'(1);
        end
        else if (hit)
        begin
            depth_reg <= depth_next;
            width_reg <= width_next;
            rows_reg  <= rows_next;
        end
    end

    always_comb
    begin
        case (index)
            sbpp_pkg::REG_DEPTH: prdata = {30'd0, depth_reg};
            sbpp_pkg::REG_WIDTH: prdata = {19'd0, width_reg};
            sbpp_pkg::REG_ROWS:  prdata = {19'd0, rows_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.depth_code = depth_reg;
    assign cfg.row_width  = width_reg;
    assign cfg.row_count  = rows_reg;
    assign cfg.clear      = hit;

endmodule

>>> src/sbpp_pack_core.sv
// Packing core: input register, packing state and the single-pass shift/OR logic.
// Depends on sbpp_pkg for cfg_t, result_t and the depth decode.
module sbpp_pack_core
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbpp_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sbpp_pkg::PixelW-1:0]   in_pixel,
    input  logic                          out_room,
    output logic                          res_valid,
    output sbpp_pkg::result_t             res
);

    localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WCapW = $clog2(MAX_WIDTH + 1);
    localparam int RCapW = $clog2(MAX_ROWS + 1);
    localparam int WCmpW = ((WCapW > sbpp_pkg::CfgW) ? WCapW : sbpp_pkg::CfgW) + 1;
    localparam int RCmpW = ((RCapW > sbpp_pkg::CfgW) ? RCapW : sbpp_pkg::CfgW) + 1;

    logic                          in_valid_reg;
    logic [sbpp_pkg::PixelW-1:0]   pix_reg;
    logic [sbpp_pkg::PixelW-1:0]   partial_reg, partial_next;
    logic [3:0]                    bits_reg, bits_next;
    logic [ColW-1:0]               col_reg, col_next;
    logic [RowW-1:0]               row_reg, row_next;

    logic                          adv;
    logic [4:0]                    bits_sum;
    logic [3:0]                    bits_new;
    logic [2:0]                    shamt;
    logic [15:0]                   shifted;
    logic [sbpp_pkg::PixelW-1:0]   byte_new;
    logic [WCmpW-1:0]              width_raw, width_eff, col_plus;
    logic [RCmpW-1:0]              rows_raw, rows_eff, row_plus;
    logic                          row_end, image_end, emit;

    assign adv      = in_valid_reg & out_room;
    assign in_ready = ~in_valid_reg | out_room;

    // Clamp the geometry registers: zero acts as one, oversize as the maximum
    assign width_raw = WCmpW'(cfg.row_width);
    assign rows_raw  = RCmpW'(cfg.row_count);
    always_comb
    begin
        if (width_raw == '0)
            width_eff = WCmpW'(1);
        else if (width_raw > WCmpW'(MAX_WIDTH))
            width_eff = WCmpW'(MAX_WIDTH);
        else
            width_eff = width_raw;
        if (rows_raw == '0)
            rows_eff = RCmpW'(1);
        else if (rows_raw > RCmpW'(MAX_ROWS))
            rows_eff = RCmpW'(MAX_ROWS);
        else
            rows_eff = rows_raw;
    end

    // Shift the unmasked pixel into the partial byte and OR it in
    assign bits_sum = {1'b0, bits_reg} + {1'b0, sbpp_pkg::depth_bits(cfg.depth_code)};
    assign bits_new = (bits_sum > 5'd8) ? 4'd8 : bits_sum[3:0];
    assign shamt    = 3'(4'd8 - bits_new);
    assign shifted  = {8'h00, pix_reg} << shamt;
    assign byte_new = partial_reg | shifted[7:0];

    assign col_plus  = WCmpW'(col_reg) + WCmpW'(1);
    assign row_plus  = RCmpW'(row_reg) + RCmpW'(1);
    assign row_end   = (col_plus >= width_eff);
    assign image_end = row_end & (row_plus >= rows_eff);
    assign emit      = (bits_new == 4'd8) | row_end;

    always_comb
    begin
        partial_next = partial_reg;
        bits_next    = bits_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (cfg.clear)
        begin
            partial_next = '0;
            bits_next    = '0;
            col_next     = '0;
            row_next     = '0;
        end
        else if (adv)
        begin
            partial_next = emit ? '0 : byte_new;
            bits_next    = emit ? 4'd0 : bits_new;
            if (row_end)
            begin
                col_next = '0;
                row_next = image_end ? '0 : row_plus[RowW-1:0];
            end
            else
            begin
                col_next = col_plus[ColW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            partial_reg  <= '0;
            bits_reg     <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            partial_reg <= partial_next;
            bits_reg    <= bits_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready & in_valid)
            pix_reg <= in_pixel;
    end

    assign res_valid        = adv & emit;
    assign res.packed_byte  = byte_new;
    assign res.end_of_row   = row_end;
    assign res.end_of_image = image_end;

endmodule

>>> src/sbpp_out_skid.sv
// Result register with a skid entry so the core keeps going while a result waits.
// Depends on sbpp_pkg for the result_t struct.
module sbpp_out_skid
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  sbpp_pkg::result_t             push_data,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sbpp_pkg::result_t             out_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    sbpp_pkg::result_t  out_data_reg, out_data_next;
    sbpp_pkg::result_t  skid_data_reg, skid_data_next;
    logic               pop;

    assign pop  = out_valid_reg & out_ready;
    assign room = ~skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
